>>> hdl/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_KNOTS  = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int KN_W       = $clog2(MAX_KNOTS);
  localparam int CNT_W      = $clog2(MAX_KNOTS + 1);
  localparam int ACT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = PT_W + KN_W;
  localparam int DEPTH      = MAX_POINTS * MAX_KNOTS;
  localparam int WORD_W     = 32;

  // Divider: (t - t0) * 2^16 over a positive 33-bit interval.
  localparam int DIVISOR_W  = WORD_W + 1;
  localparam int DIVIDEND_W = DIVISOR_W + 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Configuration register indexes.
  localparam logic REG_NUM_POINTS  = 1'b0;
  localparam logic REG_FIXED_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FLAT  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POINT,
    S_T0,
    S_T1,
    S_CHK,
    S_TN,
    S_X0,
    S_X1,
    S_DIFF,
    S_DIV,
    S_FRAC,
    S_MULX,
    S_ADDX,
    S_MULY,
    S_ADDY,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/piecewise_linear_load_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: write and count transfers are taken while idle. Per point, an evaluate run
// searches the segments one at a time, then divides in the restoring divider and
// interpolates x and y; the divider and the single-read knot memories set its pace.
// Throughput: one item at a time; an evaluate holds the input until its last
// result is transferred. Reset: synchronous, active high; clears the configuration
// registers, knot counts and the sequencer state.
module piecewise_linear_load_interp (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: point_index[3:0], entry_index[7:4], entry_count[12:8],
  // knot_time[44:13], knot_x[76:45], knot_y[108:77], last_step_time[140:109],
  // step_length[172:141], zero pad to 175.
  input  wire logic [175:0] s_axis_tdata,
  // tuser: cmd.
  input  wire logic [1:0]   s_axis_tuser,
  // Output stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: target_row[10:0], load_index[14:11], eval_time[46:15],
  // x_load[78:47], y_load[110:79], zero pad bit 111.
  output logic      [111:0] m_axis_tdata,
  // tuser: status.
  output logic      [1:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  // Configuration writes.
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [9:0]   cfg_data
);

  localparam int PW = pli_pkg::PT_W;
  localparam int KW = pli_pkg::KN_W;
  localparam int CW = pli_pkg::CNT_W;
  localparam int AW = pli_pkg::ACT_W;
  localparam int WW = pli_pkg::WORD_W;

  // Input field slices.
  logic [PW-1:0]        in_pt;
  logic [KW-1:0]        in_ent;
  logic [CW-1:0]        in_cnt;
  logic signed [WW-1:0] in_kt, in_kx, in_ky, in_lst, in_sl;
  pli_pkg::cmd_t        in_cmd;
  logic                 in_xfer;

  assign in_pt   = s_axis_tdata[3:0];
  assign in_ent  = s_axis_tdata[7:4];
  assign in_cnt  = s_axis_tdata[12:8];
  assign in_kt   = s_axis_tdata[44:13];
  assign in_kx   = s_axis_tdata[76:45];
  assign in_ky   = s_axis_tdata[108:77];
  assign in_lst  = s_axis_tdata[140:109];
  assign in_sl   = s_axis_tdata[172:141];
  assign in_cmd  = pli_pkg::cmd_t'(s_axis_tuser);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  logic [4:0] num_load_points;
  logic [9:0] fixed_point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_load_points   <= '0;
      fixed_point_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pli_pkg::REG_NUM_POINTS) begin
        num_load_points <= cfg_data[4:0];
      end else begin
        fixed_point_count <= cfg_data;
      end
    end
  end

  pli_pkg::state_t state, state_next;

  // Sequencer registers.
  logic [PW-1:0]        pt_idx;
  logic [AW-1:0]        active;
  logic [KW-1:0]        seg;
  logic [CW-1:0]        n_knots;
  logic signed [WW-1:0] t_eval;
  logic signed [WW-1:0] t0, t1, x0, x1, y0, y1;
  logic signed [WW-1:0] frac;
  logic                 num_neg;
  logic signed [64:0]   prod;
  logic signed [WW-1:0] x_res, y_res;
  pli_pkg::status_t     status;
  logic                 is_last;

  // Knot counts are small enough for flip-flops with a reset value.
  logic [CW-1:0] knot_counts [pli_pkg::MAX_POINTS];

  // Knot memories.
  logic                          ram_we;
  logic [pli_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [KW-1:0]                 kaddr;
  logic [WW-1:0]                 t_rd, x_rd, y_rd;

  assign ram_we    = in_xfer && (in_cmd == pli_pkg::CMD_WRITE)
                     && (32'(in_pt) < 32'(pli_pkg::MAX_POINTS))
                     && (32'(in_ent) < 32'(pli_pkg::MAX_KNOTS));
  assign ram_waddr = {in_pt, in_ent};
  assign ram_raddr = {pt_idx, kaddr};

  pli_ram #(.WIDTH(WW), .DEPTH(pli_pkg::DEPTH)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_kt), .raddr(ram_raddr), .rdata(t_rd)
  );
  pli_ram #(.WIDTH(WW), .DEPTH(pli_pkg::DEPTH)) u_x_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_kx), .raddr(ram_raddr), .rdata(x_rd)
  );
  pli_ram #(.WIDTH(WW), .DEPTH(pli_pkg::DEPTH)) u_y_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_ky), .raddr(ram_raddr), .rdata(y_rd)
  );

  // Step end time, saturated.
  logic signed [WW:0]   t_sum;
  logic signed [WW-1:0] t_sat;
  assign t_sum = {in_lst[WW-1], in_lst} + {in_sl[WW-1], in_sl};
  always_comb begin
    if (t_sum[WW] != t_sum[WW-1]) begin
      t_sat = t_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      t_sat = t_sum[WW-1:0];
    end
  end

  logic [AW-1:0] active_calc;
  assign active_calc = (32'(num_load_points) > 32'(pli_pkg::MAX_POINTS))
                       ? AW'(pli_pkg::MAX_POINTS) : AW'(num_load_points);

  // Segment search: the time is inside when t0 <= t <= t1, with t1 from the read port.
  logic in_seg, more_segs;
  assign in_seg    = (t0 <= t_eval) && (t_eval <= $signed(t_rd));
  assign more_segs = (CW'(seg) + CW'(2)) < n_knots;

  // Interval and offset for the fraction.
  logic signed [WW:0]               dt, num;
  logic [WW:0]                      num_mag;
  logic [pli_pkg::DIVIDEND_W-1:0]   div_q;
  logic                             div_start, div_done;

  assign dt      = {t1[WW-1], t1} - {t0[WW-1], t0};
  assign num     = {t_eval[WW-1], t_eval} - {t0[WW-1], t0};
  assign num_mag = num[WW] ? (WW+1)'(-num) : num;
  assign div_start = (state == pli_pkg::S_DIFF) && (dt > 0);

  pli_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({num_mag, 16'h0000}), .divisor(dt),
    .done(div_done), .quotient(div_q)
  );

  // Fraction: sign applied to the quotient, then saturated to 32 bits.
  logic signed [WW-1:0] frac_calc;
  always_comb begin
    if (!num_neg) begin
      frac_calc = (|div_q[pli_pkg::DIVIDEND_W-1:WW-1]) ? {1'b0, {(WW-1){1'b1}}}
                                                        : div_q[WW-1:0];
    end else begin
      frac_calc = (div_q > pli_pkg::DIVIDEND_W'(33'h0_8000_0000)) ? {1'b1, {(WW-1){1'b0}}}
                                                                  : -div_q[WW-1:0];
    end
  end

  // Shared multiplier: fraction times the load step of x or y.
  logic signed [WW:0]   mul_b;
  logic signed [64:0]   mul_p;
  logic signed [WW-1:0] base_v;
  assign mul_b  = (state == pli_pkg::S_MULY) ? ({y1[WW-1], y1} - {y0[WW-1], y0})
                                             : ({x1[WW-1], x1} - {x0[WW-1], x0});
  assign mul_p  = 65'(frac) * 65'(mul_b);
  assign base_v = (state == pli_pkg::S_ADDY) ? y0 : x0;

  // Product over 2^16 truncated toward zero, added to the left load and saturated.
  logic signed [64:0]   prod_adj;
  logic signed [48:0]   prod_q;
  logic signed [49:0]   lerp_sum;
  logic signed [WW-1:0] lerp_sat;
  always_comb begin
    prod_adj = prod[64] ? (prod + 65'sd65535) : prod;
    prod_q   = prod_adj[64:16];
    lerp_sum = 50'(prod_q) + 50'(base_v);
    if (lerp_sum > 50'sd2147483647) begin
      lerp_sat = {1'b0, {(WW-1){1'b1}}};
    end else if (lerp_sum < -50'sd2147483648) begin
      lerp_sat = {1'b1, {(WW-1){1'b0}}};
    end else begin
      lerp_sat = lerp_sum[WW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pli_pkg::S_IDLE: begin
        if (in_xfer && (in_cmd == pli_pkg::CMD_EVAL) && (active_calc != '0)) begin
          state_next = pli_pkg::S_POINT;
        end
      end
      pli_pkg::S_POINT: begin
        state_next = (knot_counts[pt_idx] < CW'(2)) ? pli_pkg::S_OUT : pli_pkg::S_T0;
      end
      pli_pkg::S_T0:  state_next = pli_pkg::S_T1;
      pli_pkg::S_T1:  state_next = pli_pkg::S_CHK;
      pli_pkg::S_TN:  state_next = pli_pkg::S_CHK;
      pli_pkg::S_CHK: begin
        state_next = (more_segs && !in_seg) ? pli_pkg::S_TN : pli_pkg::S_X0;
      end
      pli_pkg::S_X0:   state_next = pli_pkg::S_X1;
      pli_pkg::S_X1:   state_next = pli_pkg::S_DIFF;
      pli_pkg::S_DIFF: state_next = (dt > 0) ? pli_pkg::S_DIV : pli_pkg::S_OUT;
      pli_pkg::S_DIV: begin
        if (div_done) begin
          state_next = pli_pkg::S_FRAC;
        end
      end
      pli_pkg::S_FRAC: state_next = pli_pkg::S_MULX;
      pli_pkg::S_MULX: state_next = pli_pkg::S_ADDX;
      pli_pkg::S_ADDX: state_next = pli_pkg::S_MULY;
      pli_pkg::S_MULY: state_next = pli_pkg::S_ADDY;
      pli_pkg::S_ADDY: state_next = pli_pkg::S_OUT;
      pli_pkg::S_OUT: begin
        if (m_axis_tready) begin
          state_next = is_last ? pli_pkg::S_IDLE : pli_pkg::S_POINT;
        end
      end
      default: state_next = pli_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    kaddr         = seg;
    case (state)
      pli_pkg::S_IDLE: s_axis_tready = 1'b1;
      pli_pkg::S_T1,
      pli_pkg::S_TN,
      pli_pkg::S_X1:   kaddr = seg + 1'b1;
      pli_pkg::S_OUT:  m_axis_tvalid = 1'b1;
      default:         kaddr = seg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pli_pkg::S_IDLE;
      for (int k = 0; k < pli_pkg::MAX_POINTS; k++) begin
        knot_counts[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (in_xfer && (in_cmd == pli_pkg::CMD_COUNT)
          && (32'(in_pt) < 32'(pli_pkg::MAX_POINTS))) begin
        knot_counts[in_pt] <= (32'(in_cnt) > 32'(pli_pkg::MAX_KNOTS))
                              ? CW'(pli_pkg::MAX_KNOTS) : in_cnt;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pli_pkg::S_IDLE: begin
        t_eval <= t_sat;
        active <= active_calc;
        pt_idx <= '0;
      end
      pli_pkg::S_POINT: begin
        n_knots <= knot_counts[pt_idx];
        seg     <= '0;
        is_last <= (AW'(pt_idx) + AW'(1)) == active;
        status  <= pli_pkg::ST_SHORT;
        x_res   <= '0;
        y_res   <= '0;
      end
      pli_pkg::S_T1: t0 <= t_rd;
      pli_pkg::S_CHK: begin
        if (more_segs && !in_seg) begin
          seg <= seg + 1'b1;
          t0  <= t_rd;
        end else begin
          t1 <= t_rd;
        end
      end
      pli_pkg::S_X1: begin
        x0 <= x_rd;
        y0 <= y_rd;
      end
      pli_pkg::S_DIFF: begin
        x1      <= x_rd;
        y1      <= y_rd;
        num_neg <= num[WW];
        // A flat or falling interval holds the left knot.
        status  <= (dt > 0) ? pli_pkg::ST_OK : pli_pkg::ST_FLAT;
        x_res   <= x0;
        y_res   <= y0;
      end
      pli_pkg::S_FRAC: frac <= frac_calc;
      pli_pkg::S_MULX,
      pli_pkg::S_MULY: prod <= mul_p;
      pli_pkg::S_ADDX: x_res <= lerp_sat;
      pli_pkg::S_ADDY: y_res <= lerp_sat;
      pli_pkg::S_OUT: begin
        if (m_axis_tready && !is_last) begin
          pt_idx <= pt_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The result is read straight from the held registers while in the output state.
  assign m_axis_tdata = {1'b0, y_res, x_res, t_eval, pt_idx,
                         11'(fixed_point_count) + 11'(pt_idx) + 11'd1};
  assign m_axis_tuser = status;
  assign m_axis_tlast = is_last;

endmodule
`default_nettype wire

>>> hdl/pli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/pli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pli_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [pli_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [pli_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  done,
  output logic      [pli_pkg::DIVIDEND_W-1:0]   quotient
);

  logic                             busy;
  logic [pli_pkg::DIV_CNT_W-1:0]    cnt;
  logic [pli_pkg::DIVISOR_W-1:0]    rem;
  logic [pli_pkg::DIVISOR_W-1:0]    dvs;
  logic [pli_pkg::DIVISOR_W:0]      rem_sh;
  logic [pli_pkg::DIVISOR_W+1:0]    diff;

  assign rem_sh = {rem, quotient[pli_pkg::DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= pli_pkg::DIV_CNT_W'(pli_pkg::DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == pli_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[pli_pkg::DIVISOR_W+1]) begin
        rem <= diff[pli_pkg::DIVISOR_W-1:0];
      end else begin
        rem <= rem_sh[pli_pkg::DIVISOR_W-1:0];
      end
      quotient <= {quotient[pli_pkg::DIVIDEND_W-2:0], ~diff[pli_pkg::DIVISOR_W+1]};
    end
  end

endmodule
`default_nettype wire

>>> hdl/pli_check.sv
`timescale 1ns / 1ps
`default_nettype none
module pli_check (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // No input is taken while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // After the final result of a run the block takes input again.
  a_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("block did not return to idle");

  // Status is one of the three defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == pli_pkg::ST_OK) || (m_axis_tuser == pli_pkg::ST_FLAT)
    || (m_axis_tuser == pli_pkg::ST_SHORT))
    else $error("undefined status");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_load_interp pli_check u_pli_check (.*);
`default_nettype wire
